FILE: rtl/stls_pkg.sv
`default_nettype none

package stls_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_STEP_PRESCALE    = 3'd0;
    localparam logic [2:0] REG_HOLD_LIMIT       = 3'd1;
    localparam logic [2:0] REG_RELEASE_DELAY    = 3'd2;
    localparam logic [2:0] REG_STARTUP_DELAY    = 3'd3;
    localparam logic [2:0] REG_SLOW_BASE_PERIOD = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    // Register reset values
    localparam logic [7:0] STEP_PRESCALE_RST    = 8'd40;
    localparam logic [9:0] HOLD_LIMIT_RST       = 10'd500;
    localparam logic [7:0] RELEASE_DELAY_RST    = 8'd10;
    localparam logic [7:0] STARTUP_DELAY_RST    = 8'd5;
    localparam logic [7:0] SLOW_BASE_PERIOD_RST = 8'd100;

    // Auxiliary lamp taps on the pattern
    localparam int AUX_LOW_BIT  = 0;
    localparam int AUX_HIGH_BIT = 4;

    typedef struct packed {
        logic [7:0] step_prescale;
        logic [9:0] hold_limit;
        logic [7:0] release_delay;
        logic [7:0] slow_base_period;
    } cfg_t;

    typedef struct packed {
        logic [7:0] lamp_pattern;
        logic       running_lamp_on;
        logic       heartbeat;
    } result_t;

    // Fixed sweep table: lamps fill in from the low end, top lamp always lit
    function automatic logic [7:0] lamp_lookup(input logic [2:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0:    val = 8'h80;
            3'd1:    val = 8'h81;
            3'd2:    val = 8'h83;
            3'd3:    val = 8'h87;
            3'd4:    val = 8'h8f;
            3'd5:    val = 8'h9f;
            3'd6:    val = 8'hbf;
            3'd7:    val = 8'hff;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/stls_cfg_regs.sv
`default_nettype none

module stls_cfg_regs (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [stls_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [stls_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output stls_pkg::cfg_t                         cfg
);

    stls_pkg::cfg_t cfg_reg;

    // Register file; the startup delay only loads the delay counter at reset,
    // where its reset value always applies, so its writes are dropped here.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_prescale    <= stls_pkg::STEP_PRESCALE_RST;
            cfg_reg.hold_limit       <= stls_pkg::HOLD_LIMIT_RST;
            cfg_reg.release_delay    <= stls_pkg::RELEASE_DELAY_RST;
            cfg_reg.slow_base_period <= stls_pkg::SLOW_BASE_PERIOD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                stls_pkg::REG_STEP_PRESCALE:    cfg_reg.step_prescale    <= cfg_wdata[7:0];
                stls_pkg::REG_HOLD_LIMIT:       cfg_reg.hold_limit       <= cfg_wdata[9:0];
                stls_pkg::REG_RELEASE_DELAY:    cfg_reg.release_delay    <= cfg_wdata[7:0];
                stls_pkg::REG_STARTUP_DELAY:    cfg_reg <= cfg_reg;
                stls_pkg::REG_SLOW_BASE_PERIOD: cfg_reg.slow_base_period <= cfg_wdata[7:0];
                default:                        cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/stls_tick_core.sv
`default_nettype none

module stls_tick_core #(
    parameter int PATTERN_STEPS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        tick_en,
    input  wire logic        trig,
    input  wire stls_pkg::cfg_t cfg,
    output stls_pkg::result_t result
);

    logic       trig_latched_reg, trig_latched_next;
    logic       sweep_active_reg, sweep_active_next;
    logic [2:0] step_index_reg, step_index_next;
    logic [7:0] prescale_reg, prescale_next;
    logic [9:0] hold_count_reg, hold_count_next;
    logic       delay_active_reg, delay_active_next;
    logic [7:0] delay_rem_reg, delay_rem_next;
    logic [7:0] base_ticks_reg, base_ticks_next;
    logic [7:0] pattern_reg, pattern_next;
    logic       running_reg, running_next;
    logic       heartbeat_reg, heartbeat_next;

    logic [9:0] hold_inc;
    logic [3:0] step_inc;
    logic [7:0] base_inc;

    assign hold_inc = hold_count_reg + 10'd1;
    assign step_inc = {1'b0, step_index_reg} + 4'd1;
    assign base_inc = base_ticks_reg + 8'd1;

    // One tick: heartbeat, trigger edge / hold, sweep step, slow base and delay
    always_comb begin
        trig_latched_next = trig_latched_reg;
        sweep_active_next = sweep_active_reg;
        step_index_next   = step_index_reg;
        prescale_next     = prescale_reg;
        hold_count_next   = hold_count_reg;
        delay_active_next = delay_active_reg;
        delay_rem_next    = delay_rem_reg;
        base_ticks_next   = base_ticks_reg;
        pattern_next      = pattern_reg;
        running_next      = running_reg;
        heartbeat_next    = heartbeat_reg;

        if (tick_en) begin
            heartbeat_next = ~heartbeat_reg;

            // trigger handling
            if (trig) begin
                if (!trig_latched_reg) begin
                    trig_latched_next = 1'b1;
                    prescale_next     = cfg.step_prescale;
                    sweep_active_next = 1'b1;
                    running_next      = 1'b0;
                    hold_count_next   = 10'd0;
                end else begin
                    hold_count_next = hold_inc;
                    if (hold_inc >= cfg.hold_limit) begin
                        hold_count_next = 10'd0;
                        running_next    = 1'b1;
                        pattern_next    = 8'd0;
                    end
                end
            end else begin
                if (trig_latched_reg) begin
                    trig_latched_next = 1'b0;
                    delay_active_next = 1'b1;
                    delay_rem_next    = cfg.release_delay;
                end
                pattern_next      = 8'd0;
                sweep_active_next = 1'b0;
            end

            // sweep step; index survives an aborted sweep
            if (sweep_active_next) begin
                if (prescale_next != 8'd0) begin
                    prescale_next = prescale_next - 8'd1;
                end else begin
                    prescale_next = cfg.step_prescale;
                    pattern_next  = stls_pkg::lamp_lookup(step_index_reg);
                    if (step_inc >= 4'(PATTERN_STEPS)) begin
                        step_index_next   = 3'd0;
                        sweep_active_next = 1'b0;
                    end else begin
                        step_index_next = step_inc[2:0];
                    end
                end
            end

            // free-running slow base drives the delay countdown
            base_ticks_next = base_inc;
            if (base_inc >= cfg.slow_base_period) begin
                base_ticks_next = 8'd0;
                if (delay_active_next) begin
                    if (delay_rem_next != 8'd0) begin
                        delay_rem_next = delay_rem_next - 8'd1;
                    end else begin
                        delay_active_next = 1'b0;
                        running_next      = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trig_latched_reg <= 1'b0;
            sweep_active_reg <= 1'b0;
            step_index_reg   <= 3'd0;
            prescale_reg     <= 8'd0;
            hold_count_reg   <= 10'd0;
            delay_active_reg <= 1'b1;
            delay_rem_reg    <= stls_pkg::STARTUP_DELAY_RST;
            base_ticks_reg   <= 8'd0;
            pattern_reg      <= 8'd0;
            running_reg      <= 1'b0;
            heartbeat_reg    <= 1'b0;
        end else begin
            trig_latched_reg <= trig_latched_next;
            sweep_active_reg <= sweep_active_next;
            step_index_reg   <= step_index_next;
            prescale_reg     <= prescale_next;
            hold_count_reg   <= hold_count_next;
            delay_active_reg <= delay_active_next;
            delay_rem_reg    <= delay_rem_next;
            base_ticks_reg   <= base_ticks_next;
            pattern_reg      <= pattern_next;
            running_reg      <= running_next;
            heartbeat_reg    <= heartbeat_next;
        end
    end

    // result reflects the state after this tick
    assign result.lamp_pattern    = pattern_next;
    assign result.running_lamp_on = running_next;
    assign result.heartbeat       = heartbeat_next;

    // step index never leaves the active part of the table
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, step_index_reg} < 4'(PATTERN_STEPS))
        else $error("step index out of range");

    // heartbeat flips on every tick
    a_hb_toggle: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_en |=> heartbeat_reg != $past(heartbeat_reg))
        else $error("heartbeat did not toggle");

    // no tick, no state change
    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !tick_en |=> $stable(step_index_reg) && $stable(pattern_reg)
                     && $stable(base_ticks_reg))
        else $error("state moved without a tick");

    // released trigger blanks the lamps and stops the sweep
    a_release_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_en && !trig |=> pattern_reg == 8'd0 && !sweep_active_reg
                             && !trig_latched_reg)
        else $error("lamps not blanked on release");

endmodule

`default_nettype wire

FILE: rtl/sequential_turn_lamp_sequencer.sv
// Pipeline: a request goes into the input register, then its result into the result
// register, which drives m_valid.
// Throughput: one request per cycle while results are taken; with a result stalled, one
// more request waits in the input register before s_ready drops.
// Reset: synchronous, active low; registers at defaults, startup delay armed.
`default_nettype none

module sequential_turn_lamp_sequencer #(
    parameter int PATTERN_STEPS = 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration
    input  wire logic                              cfg_wr_en,
    input  wire logic [stls_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [stls_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // tick requests
    input  wire logic                              s_valid,
    output      logic                              s_ready,
    input  wire logic                              s_trigger_level,
    // results
    output      logic                              m_valid,
    input  wire logic                              m_ready,
    output      logic [7:0]                        m_lamp_pattern,
    output      logic                              m_aux_lamp_low,
    output      logic                              m_aux_lamp_high,
    output      logic                              m_running_lamp_on,
    output      logic                              m_heartbeat
);

    stls_pkg::cfg_t    cfg;
    stls_pkg::result_t core_result;

    logic              in_valid_reg;
    logic              in_trig_reg;
    logic              out_valid_reg;
    stls_pkg::result_t out_reg;
    logic              out_load;
    logic              tick_en;

    stls_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // pipeline control: result register frees when empty or taken
    assign out_load = !out_valid_reg || m_ready;
    assign tick_en  = in_valid_reg && out_load;
    assign s_ready  = !in_valid_reg || out_load;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_trig_reg <= s_trigger_level;
        end
    end

    stls_tick_core #(
        .PATTERN_STEPS (PATTERN_STEPS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick_en (tick_en),
        .trig    (in_trig_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_en) begin
            out_reg <= core_result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_lamp_pattern    = out_reg.lamp_pattern;
    assign m_aux_lamp_low    = out_reg.lamp_pattern[stls_pkg::AUX_LOW_BIT];
    assign m_aux_lamp_high   = out_reg.lamp_pattern[stls_pkg::AUX_HIGH_BIT];
    assign m_running_lamp_on = out_reg.running_lamp_on;
    assign m_heartbeat       = out_reg.heartbeat;

endmodule

`default_nettype wire
